/* rtl/core/fpba_pkg.sv */
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and constants of the fit-policy block allocator: policy codes,
// configuration register indexes and the search token that runs along the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_FIT_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 2'd1;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_mode_t;

  // Control part of the search token handed from cell to cell
  typedef struct packed {
    logic active;
    logic found;
    logic pass;
  } tok_ctrl_t;

  // Broadcast to every cell during a search
  typedef struct packed {
    logic      run;
    fit_mode_t mode;
  } search_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/fit_policy_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core
// Free-capacity table kept in a row of cells; a search token walks the row one
// cell per cycle and picks a block under first, best, worst or next fit.
// ----------------------------------------------------------------------------
// Load request: busy stays low; the entry is written at the accept edge.
// Allocation: the token moves one cell per cycle over the n blocks in use, and next
//   fit walks them twice.
// The result strobe comes in the first cycle with busy low; it cannot be stalled.
// Synchronous reset clears control, fit_mode (first fit), block_count (MAX) and the
//   rover; table contents are undefined until loaded.
`default_nettype none

module fit_policy_block_allocator_core #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
  localparam int IW = $clog2(MAX_BLOCKS),
  localparam int CW = IW + 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             req_type,
  input  wire logic [IW-1:0]                    block_index,
  input  wire logic [SIZE_BITS-1:0]             amount,
  output logic                                  done,
  output logic                                  granted,
  output logic [IW-1:0]                         chosen_block,
  output logic [SIZE_BITS-1:0]                  capacity_left,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fpba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CW-1:0]                    cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  state_t                state;
  fpba_pkg::fit_mode_t   fit_mode;
  logic [CW-1:0]         block_count;
  logic [IW-1:0]         rover;
  logic [SIZE_BITS-1:0]  need;
  logic [IW-1:0]         start_pos;
  logic [CW:0]           total_steps;
  logic [CW:0]           step;

  logic [CW-1:0]         n_eff;
  logic [CW-1:0]         n_m1;
  logic [IW-1:0]         ring_sel;
  logic                  accept;
  logic                  hit;
  logic                  wr_en;
  logic [IW-1:0]         wr_idx;
  logic [SIZE_BITS-1:0]  wr_data;
  fpba_pkg::search_ctl_t ctl;

  fpba_pkg::tok_ctrl_t   tout_ctrl [MAX_BLOCKS];
  logic [IW-1:0]         tout_idx  [MAX_BLOCKS];
  logic [SIZE_BITS-1:0]  tout_cap  [MAX_BLOCKS];
  fpba_pkg::tok_ctrl_t   tin_ctrl  [MAX_BLOCKS];
  logic [IW-1:0]         tin_idx   [MAX_BLOCKS];
  logic [SIZE_BITS-1:0]  tin_cap   [MAX_BLOCKS];

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign n_eff    = (block_count > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : block_count;
  assign n_m1     = n_eff - CW'(1);
  assign ring_sel = n_m1[IW-1:0];
  assign hit      = (n_eff != '0) && tout_ctrl[ring_sel].found;

  assign ctl.run  = (state == ST_SEARCH);
  assign ctl.mode = fit_mode;

  // Ring links: the last cell in use feeds cell 0 and opens the second pass
  always_comb begin
    tin_ctrl[0]      = tout_ctrl[ring_sel];
    tin_ctrl[0].pass = 1'b1;
    tin_idx[0]       = tout_idx[ring_sel];
    tin_cap[0]       = tout_cap[ring_sel];
  end

  for (genvar i = 1; i < MAX_BLOCKS; i++) begin : g_link
    always_comb begin
      tin_ctrl[i]        = tout_ctrl[i-1];
      tin_ctrl[i].active = tout_ctrl[i-1].active && (CW'(i) < n_eff);
      tin_idx[i]         = tout_idx[i-1];
      tin_cap[i]         = tout_cap[i-1];
    end
  end

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    fpba_cell #(
      .IW       (IW),
      .SB       (SIZE_BITS),
      .CELL_IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .ctl       (ctl),
      .need      (need),
      .start_pos (start_pos),
      .inject    ((i == 0) && (state == ST_SEARCH) && (step == '0)),
      .tin_ctrl  (tin_ctrl[i]),
      .tin_idx   (tin_idx[i]),
      .tin_cap   (tin_cap[i]),
      .tout_ctrl (tout_ctrl[i]),
      .tout_idx  (tout_idx[i]),
      .tout_cap  (tout_cap[i])
    );
  end

  // Table write port: loads at accept, charge of the chosen block at the end
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = block_index;
    wr_data = amount;
    if (accept && req_type == fpba_pkg::REQ_LOAD &&
        {1'b0, block_index} < CW'(MAX_BLOCKS)) begin
      wr_en = 1'b1;
    end
    if (state == ST_DONE) begin
      wr_idx  = tout_idx[ring_sel];
      wr_data = tout_cap[ring_sel] - need;
      wr_en   = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode    <= fpba_pkg::FIT_FIRST;
      block_count <= CW'(MAX_BLOCKS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpba_pkg::REG_FIT_MODE:    fit_mode    <= fpba_pkg::fit_mode_t'(cfg_data[1:0]);
        fpba_pkg::REG_BLOCK_COUNT: block_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rover   <= '0;
      done    <= 1'b0;
      granted <= 1'b0;
      step    <= '0;
    end else begin
      done    <= 1'b0;
      granted <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req_type == fpba_pkg::REQ_LOAD) begin
              rover <= '0;
            end else begin
              need        <= amount;
              start_pos   <= ({1'b0, rover} < n_eff) ? rover : '0;
              total_steps <= (fit_mode == fpba_pkg::FIT_NEXT) ? {n_eff, 1'b0}
                                                               : {1'b0, n_eff};
              step        <= '0;
              state       <= (n_eff == '0) ? ST_DONE : ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          step <= step + (CW+1)'(1);
          if (step == total_steps - (CW+1)'(1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          done          <= 1'b1;
          granted       <= hit;
          chosen_block  <= hit ? tout_idx[ring_sel] : '0;
          capacity_left <= hit ? wr_data : '0;
          if (hit && fit_mode == fpba_pkg::FIT_NEXT) begin
            rover <= tout_idx[ring_sel];
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fpba_cell.sv */
// ----------------------------------------------------------------------------
// fpba_cell
// One table entry: holds a block capacity, takes broadcast writes, and updates
// the search token that passes through it on the way to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_cell #(
  parameter int IW       = 4,
  parameter int SB       = 16,
  parameter int CELL_IDX = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [IW-1:0]         wr_idx,
  input  wire logic [SB-1:0]         wr_data,
  input  wire fpba_pkg::search_ctl_t ctl,
  input  wire logic [SB-1:0]         need,
  input  wire logic [IW-1:0]         start_pos,
  input  wire logic                  inject,
  input  wire fpba_pkg::tok_ctrl_t   tin_ctrl,
  input  wire logic [IW-1:0]         tin_idx,
  input  wire logic [SB-1:0]         tin_cap,
  output fpba_pkg::tok_ctrl_t        tout_ctrl,
  output logic [IW-1:0]              tout_idx,
  output logic [SB-1:0]              tout_cap
);

  localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

  logic [SB-1:0]       cap;
  fpba_pkg::tok_ctrl_t cin_ctrl;
  logic [IW-1:0]       cin_idx;
  logic [SB-1:0]       cin_cap;
  logic                fits;
  logic                eligible;
  logic                better;
  logic                take;

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == MY_IDX) begin
      cap <= wr_data;
    end
  end

  // Fresh token enters at the head of the row
  always_comb begin
    if (inject) begin
      cin_ctrl = '{active: 1'b1, found: 1'b0, pass: 1'b0};
      cin_idx  = '0;
      cin_cap  = '0;
    end else begin
      cin_ctrl = tin_ctrl;
      cin_idx  = tin_idx;
      cin_cap  = tin_cap;
    end
  end

  always_comb begin
    fits     = cap >= need;
    eligible = 1'b1;
    better   = 1'b0;
    case (ctl.mode)
      fpba_pkg::FIT_BEST:  better = cap < cin_cap;
      fpba_pkg::FIT_WORST: better = cap > cin_cap;
      // next fit: first pass covers the rover and above, second pass the rest
      fpba_pkg::FIT_NEXT:  eligible = cin_ctrl.pass ? (MY_IDX < start_pos)
                                                    : (MY_IDX >= start_pos);
      default:             better = 1'b0;
    endcase
    take = cin_ctrl.active && eligible && fits && (!cin_ctrl.found || better);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout_ctrl <= '0;
    end else begin
      tout_ctrl.active <= ctl.run && cin_ctrl.active;
      tout_ctrl.found  <= cin_ctrl.found || take;
      tout_ctrl.pass   <= cin_ctrl.pass;
    end
  end

  always_ff @(posedge clk) begin
    tout_idx <= take ? MY_IDX : cin_idx;
    tout_cap <= take ? cap : cin_cap;
  end

endmodule

`default_nettype wire

/* rtl/core/fpba_checker.sv */
// ----------------------------------------------------------------------------
// fpba_checker
// Port-level checks of the allocator: result strobe timing against busy, and
// the shape of refused results.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_checker #(
  parameter int IW = 4,
  parameter int SB = 16
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          req_type,
  input wire logic          done,
  input wire logic          granted,
  input wire logic [IW-1:0] chosen_block,
  input wire logic [SB-1:0] capacity_left
);

  // An accepted allocation request holds the block busy next cycle
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == fpba_pkg::REQ_ALLOC |=> busy)
    else $error("allocation request did not raise busy");

  // A result shows only once the block is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_grant_strobe: assert property (@(posedge clk) disable iff (rst)
    granted |-> done)
    else $error("granted without result strobe");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && !granted |-> chosen_block == '0 && capacity_left == '0)
    else $error("refused result carries nonzero fields");

endmodule

bind fit_policy_block_allocator_core fpba_checker #(
  .IW ($clog2(MAX_BLOCKS)),
  .SB (SIZE_BITS)
) u_fpba_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .req_type      (req_type),
  .done          (done),
  .granted       (granted),
  .chosen_block  (chosen_block),
  .capacity_left (capacity_left)
);

`default_nettype wire

/* bench/fit_policy_block_allocator_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core_test
// Self-checking bench for the fit-policy block allocator. A shadow table of
// free capacities predicts every allocation under first, best, worst and next
// fit. A directed part covers the table extremes, each policy, zero-size and
// refused requests, and block_count edge values. Random traffic then runs
// across several policy settings and sender idle rates.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_core_test;
  import fpba_pkg::*;

  localparam int NUM_BLOCKS    = 16;
  localparam int SETTLE_CYCLES = 2 * NUM_BLOCKS + 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_GAP       = 40;
  localparam int PHASE_ITEMS   = 250;
  localparam int NUM_PHASES    = 8;
  localparam int MAX_PRINTS    = 20;

  typedef struct {
    logic        granted;
    logic [3:0]  block;
    logic [15:0] left;
  } grant_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   req_type;
  logic [3:0]             block_index;
  logic [15:0]            amount;
  logic                   done;
  logic                   granted;
  logic [3:0]             chosen_block;
  logic [15:0]            capacity_left;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [4:0]             cfg_data;

  // Shadow of the allocator state
  logic [15:0] free_cap [NUM_BLOCKS];
  int          rover;
  fit_mode_t   cur_mode;
  logic [4:0]  cur_count;
  grant_t      pending_grants [$];

  int fail_count      = 0;
  int cycle_count     = 0;
  int sender_idle_pct = 0;

  fit_policy_block_allocator_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .block_index   (block_index),
    .amount        (amount),
    .done          (done),
    .granted       (granted),
    .chosen_block  (chosen_block),
    .capacity_left (capacity_left),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < MAX_PRINTS)
      $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Index of the block the policy picks, -1 when nothing fits
  function automatic int choose_block(input logic [15:0] need, input int n);
    int pick;
    int pos;
    int i;
    pick = -1;
    if (cur_mode == FIT_NEXT) begin
      pos = (rover < n) ? rover : 0;
      for (i = 0; i < n; i++) begin
        if (free_cap[pos] >= need)
          return pos;
        pos = (pos + 1 == n) ? 0 : pos + 1;
      end
      return -1;
    end
    for (i = 0; i < n; i++) begin
      if (free_cap[i] >= need) begin
        if (pick < 0)
          pick = i;
        else if (cur_mode == FIT_BEST && free_cap[i] < free_cap[pick])
          pick = i;
        else if (cur_mode == FIT_WORST && free_cap[i] > free_cap[pick])
          pick = i;
      end
    end
    return pick;
  endfunction

  task automatic apply_request(input logic kind, input logic [3:0] idx,
                               input logic [15:0] amt);
    int     n;
    int     pick;
    grant_t g;
    if (kind == REQ_LOAD) begin
      free_cap[idx] = amt;
      rover = 0;
      return;
    end
    n = (cur_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(cur_count);
    pick = choose_block(amt, n);
    if (pick < 0) begin
      g.granted = 1'b0;
      g.block   = '0;
      g.left    = '0;
    end else begin
      free_cap[pick] = free_cap[pick] - amt;
      if (cur_mode == FIT_NEXT)
        rover = pick;
      g.granted = 1'b1;
      g.block   = 4'(pick);
      g.left    = free_cap[pick];
    end
    pending_grants.push_back(g);
  endtask

  function automatic int draw_gap();
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
      gap++;
    return gap;
  endfunction

  task automatic send_request(input logic kind, input logic [3:0] idx,
                              input logic [15:0] amt);
    int gap;
    start       <= 1'b1;
    req_type    <= kind;
    block_index <= idx;
    amount      <= amt;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_request(kind, idx, amt);
    gap = draw_gap();
    // Keep start high for a back-to-back request
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait out every pending result plus a search that may still be running
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [4:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FIT_MODE)
      cur_mode = fit_mode_t'(data[1:0]);
    else if (idx == REG_BLOCK_COUNT)
      cur_count = data;
    @(posedge clk);
  endtask

  task automatic set_policy(input fit_mode_t mode, input logic [4:0] count);
    logic [2:0] junk;
    drain_results();
    // Upper bits of the mode write carry noise; only the low two count
    junk = 3'($urandom_range(0, 7));
    write_register(REG_FIT_MODE, {junk, mode});
    write_register(REG_BLOCK_COUNT, count);
  endtask

  task automatic test_table_load();
    int          i;
    logic [15:0] cap;
    for (i = 0; i < NUM_BLOCKS; i++) begin
      case (i)
        0:       cap = 16'h0000;
        15:      cap = 16'hFFFF;
        default: cap = 16'(1000 * i + 7 * (i % 3));
      endcase
      send_request(REQ_LOAD, 4'(i), cap);
    end
  endtask

  task automatic test_policies();
    fit_mode_t mode;
    mode = FIT_FIRST;
    repeat (4) begin
      set_policy(mode, 5'd16);
      send_request(REQ_ALLOC, 4'hF, 16'd1200);
      send_request(REQ_ALLOC, 4'h0, 16'd0);
      mode = fit_mode_t'(mode + 1);
    end
  endtask

  task automatic test_block_counts();
    // No entries in use: refuse
    set_policy(FIT_FIRST, 5'd0);
    send_request(REQ_ALLOC, 4'h5, 16'd0);
    set_policy(FIT_BEST, 5'd1);
    send_request(REQ_ALLOC, 4'hA, 16'd0);
    // Saturate to the full table
    set_policy(FIT_WORST, 5'd31);
    send_request(REQ_ALLOC, 4'h3, 16'd1);
  endtask

  task automatic test_next_fit_edges();
    set_policy(FIT_NEXT, 5'd16);
    // Park the pointer on the top block, then refuse without moving it
    send_request(REQ_ALLOC, 4'h0, 16'd30000);
    send_request(REQ_ALLOC, 4'h0, 16'hFFFF);
    // Shrink the table under the pointer: search restarts at block 0
    set_policy(FIT_NEXT, 5'd4);
    send_request(REQ_ALLOC, 4'h0, 16'd1);
  endtask

  task automatic test_random_traffic();
    int          phase;
    int          k;
    int          r;
    fit_mode_t   mode;
    logic [4:0]  count;
    logic        kind;
    logic [15:0] amt;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin mode = FIT_FIRST; count = 5'd16; end
        1: begin mode = FIT_BEST;  count = 5'd1;  end
        2: begin mode = FIT_WORST; count = 5'd31; end
        3: begin mode = FIT_NEXT;  count = 5'd16; end
        default: begin
          mode  = fit_mode_t'($urandom_range(0, 3));
          count = 5'($urandom_range(1, 20));
        end
      endcase
      set_policy(mode, count);
      case (phase % 3)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 85;
        default: sender_idle_pct = 15;
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        kind = ($urandom_range(0, 99) < 20) ? REQ_LOAD : REQ_ALLOC;
        r = $urandom_range(0, 99);
        if (kind == REQ_LOAD)
          amt = (r < 70) ? 16'($urandom_range(0, 30000)) : 16'($urandom);
        else if (r < 60)
          amt = 16'($urandom_range(0, 3000));
        else if (r < 90)
          amt = 16'($urandom_range(0, 20000));
        else
          amt = 16'($urandom);
        send_request(kind, 4'($urandom_range(0, 15)), amt);
      end
    end
    sender_idle_pct = 0;
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (!rst && done === 1'b1) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("result with no request pending", 1, 0);
      end else begin
        want = pending_grants.pop_front();
        if (granted !== want.granted)
          report_mismatch("granted", granted, want.granted);
        if (chosen_block !== want.block)
          report_mismatch("chosen_block", chosen_block, want.block);
        if (capacity_left !== want.left)
          report_mismatch("capacity_left", capacity_left, want.left);
      end
    end
  end

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    req_type    <= REQ_LOAD;
    block_index <= '0;
    amount      <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_FIT_MODE;
    cfg_data    <= '0;
    rover       = 0;
    cur_mode    = FIT_FIRST;
    cur_count   = 5'd16;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_load();
    test_policies();
    test_block_counts();
    test_next_fit_edges();
    test_random_traffic();
    drain_results();

    if (fail_count == 0 && pending_grants.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
